[src/bapp_pkg.sv]
package bapp_pkg;

   localparam int DATA_W  = 32;
   localparam int STEPS_W = 9;
   localparam int IDX_W   = 3;

   typedef enum logic [IDX_W-1:0] {
      CSR_NUM_STEPS = 3'd0,
      CSR_UP_FACTOR = 3'd1,
      CSR_DOWN_FACTOR = 3'd2,
      CSR_UP_PROB = 3'd3,
      CSR_DISCOUNT = 3'd4
   } csr_idx_type;

   localparam logic [STEPS_W-1:0] NUM_STEPS_RESET = 9'd64;
   localparam logic [DATA_W-1:0]  UP_FACTOR_RESET = 32'h4000_0000;
   localparam logic [DATA_W-1:0]  DOWN_FACTOR_RESET = 32'h4000_0000;
   localparam logic [DATA_W-1:0]  UP_PROB_RESET = 32'h8000_0000;
   localparam logic [DATA_W-1:0]  DISCOUNT_RESET = 32'hFFFF_FFFF;

   // 1.0 in Q2.30, used to pass the spot price through the multiplier
   localparam logic [DATA_W-1:0]  FACTOR_ONE = 32'h4000_0000;

   typedef struct packed {
      logic [DATA_W-1:0] up_factor;
      logic [DATA_W-1:0] down_factor;
      logic [DATA_W-1:0] up_prob;
      logic [DATA_W-1:0] discount_factor;
   } cfg_type;

   // one node operation issued by the sequencer
   typedef struct packed {
      logic valid;
      logic fwd;     // forward price pass (leaf payoff written alongside)
      logic seed;    // root node: spot price instead of memory data
      logic prime;   // backward level start: load lower child value only
      logic down;    // forward pass: scale by down factor
      logic last;    // this write produces the root value
   } op_flags_type;

endpackage

[src/bapp_req_if.sv]
interface bapp_req_if import bapp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] spot_price;
   logic [DATA_W-1:0] strike_price;

   modport source (output valid, output spot_price, output strike_price, input ready);
   modport sink (input valid, input spot_price, input strike_price, output ready);
endinterface

[src/bapp_rsp_if.sv]
interface bapp_rsp_if import bapp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] put_value;

   modport source (output valid, output put_value, input ready);
   modport sink (input valid, input put_value, output ready);
endinterface

[src/bapp_csr_if.sv]
interface bapp_csr_if import bapp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[src/bapp_seq.sv]
module bapp_seq import bapp_pkg::*; #(
   parameter int MAX_STEPS = 256,
   localparam int ADDR_W = $clog2(MAX_STEPS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] steps,
   input  logic              busy,
   input  logic              rsp_free,
   output logic              ready,
   output op_flags_type      op,
   output logic [ADDR_W-1:0] rd_addr,
   output logic [ADDR_W-1:0] wr_addr,
   output logic              result_load
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_FWD,
      ST_BWD,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   localparam logic [ADDR_W-1:0] ONE = ADDR_W'(1);

   state_type         state_ff;
   state_type         ret_ff;
   logic [ADDR_W-1:0] level_ff;
   logic [ADDR_W-1:0] k_ff;
   logic [ADDR_W-1:0] n_ff;
   logic              dphase_ff;

   assign ready       = (state_ff == ST_IDLE);
   assign result_load = (state_ff == ST_FINISH) && rsp_free;

   always_comb begin
      op      = '0;
      rd_addr = '0;
      wr_addr = '0;
      case (state_ff)
         ST_SEED: begin
            op.valid = 1'b1;
            op.fwd   = 1'b1;
            op.seed  = 1'b1;
            op.last  = (n_ff == '0);
         end
         ST_FWD: begin
            // descending sweep: node k+1 <- node k * u, then node 0 <- node 0 * d
            op.valid = 1'b1;
            op.fwd   = 1'b1;
            op.down  = dphase_ff;
            rd_addr  = dphase_ff ? '0 : k_ff;
            wr_addr  = dphase_ff ? '0 : k_ff + ONE;
         end
         ST_BWD: begin
            // ascending sweep: read k, write node k-1 from children k-1 and k
            op.valid = 1'b1;
            op.prime = (k_ff == '0);
            op.last  = (level_ff == ONE) && (k_ff != '0);
            rd_addr  = k_ff;
            wr_addr  = k_ff - ONE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ret_ff    <= ST_IDLE;
         level_ff  <= '0;
         k_ff      <= '0;
         n_ff      <= '0;
         dphase_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  n_ff     <= steps;
                  state_ff <= ST_SEED;
               end
            end
            ST_SEED: begin
               state_ff <= ST_DRAIN;
               if (n_ff == '0) begin
                  ret_ff <= ST_FINISH;
               end else begin
                  ret_ff    <= ST_FWD;
                  level_ff  <= ONE;
                  k_ff      <= '0;
                  dphase_ff <= 1'b0;
               end
            end
            ST_FWD: begin
               if (!dphase_ff) begin
                  if (k_ff == '0) begin
                     dphase_ff <= 1'b1;
                  end else begin
                     k_ff <= k_ff - ONE;
                  end
               end else begin
                  state_ff <= ST_DRAIN;
                  if (level_ff == n_ff) begin
                     ret_ff <= ST_BWD;
                     k_ff   <= '0;
                  end else begin
                     ret_ff    <= ST_FWD;
                     k_ff      <= level_ff;
                     level_ff  <= level_ff + ONE;
                     dphase_ff <= 1'b0;
                  end
               end
            end
            ST_BWD: begin
               if (k_ff == level_ff) begin
                  state_ff <= ST_DRAIN;
                  if (level_ff == ONE) begin
                     ret_ff <= ST_FINISH;
                  end else begin
                     ret_ff   <= ST_BWD;
                     level_ff <= level_ff - ONE;
                     k_ff     <= '0;
                  end
               end else begin
                  k_ff <= k_ff + ONE;
               end
            end
            ST_DRAIN: begin
               // next level reads entries the pipeline may still be writing
               if (!busy) begin
                  state_ff <= ret_ff;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[src/bapp_dp.sv]
module bapp_dp import bapp_pkg::*; #(
   parameter int MAX_STEPS = 256,
   localparam int ADDR_W = $clog2(MAX_STEPS + 1),
   localparam int MEM_D = MAX_STEPS + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  op_flags_type      op,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] spot,
   input  logic [DATA_W-1:0] strike,
   input  cfg_type           cfg,
   output logic              busy,
   output logic [DATA_W-1:0] result
);

   logic [DATA_W-1:0] price_mem [MEM_D];
   logic [DATA_W-1:0] value_mem [MEM_D];

   logic [DATA_W-1:0] price_rd_ff;
   logic [DATA_W-1:0] value_rd_ff;

   op_flags_type      s1_op_ff, s2_op_ff, s3_op_ff, s4_op_ff;
   logic [ADDR_W-1:0] s1_wr_ff, s2_wr_ff, s3_wr_ff, s4_wr_ff;

   // stage 1: products
   logic [DATA_W-1:0]        price_src;
   logic [DATA_W-1:0]        factor;
   logic [2*DATA_W-1:0]      prod_price;
   logic signed [DATA_W:0]   diff;
   logic signed [2*DATA_W+1:0] prod_q;
   logic [DATA_W-1:0]        vprev_ff;

   // stage 2: saturate, expectation
   logic [2*DATA_W-1:0] s2_prodp_ff;
   logic [DATA_W-1:0]   s2_qterm_ff;
   logic [DATA_W-1:0]   s2_vdown_ff;
   logic [DATA_W-1:0]   price_sat;

   // stage 3: discount, exercise
   logic [DATA_W-1:0]   s3_price_ff;
   logic [DATA_W-1:0]   s3_expect_ff;

   // stage 4: max, write back
   logic [2*DATA_W-1:0] s4_holdp_ff;
   logic [DATA_W-1:0]   s4_ex_ff;
   logic [DATA_W-1:0]   s4_price_ff;
   logic [DATA_W-1:0]   hold;
   logic [DATA_W-1:0]   value_new;
   logic                wr_en;
   logic [DATA_W-1:0]   result_ff;

   assign wr_en = s4_op_ff.valid && !s4_op_ff.prime;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         price_mem[s4_wr_ff] <= s4_price_ff;
      end
      price_rd_ff <= price_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[s4_wr_ff] <= value_new;
      end
      value_rd_ff <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff <= '0;
         s2_op_ff <= '0;
         s3_op_ff <= '0;
         s4_op_ff <= '0;
      end else begin
         s1_op_ff <= op;
         s2_op_ff <= s1_op_ff;
         s3_op_ff <= s2_op_ff;
         s4_op_ff <= s3_op_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_wr_ff <= wr_addr;
      s2_wr_ff <= s1_wr_ff;
      s3_wr_ff <= s2_wr_ff;
      s4_wr_ff <= s3_wr_ff;
   end

   assign busy = s1_op_ff.valid || s2_op_ff.valid || s3_op_ff.valid || s4_op_ff.valid;

   always_comb begin
      price_src = s1_op_ff.seed ? spot : price_rd_ff;
      if (s1_op_ff.seed) begin
         factor = FACTOR_ONE;
      end else if (s1_op_ff.fwd && !s1_op_ff.down) begin
         factor = cfg.up_factor;
      end else begin
         factor = cfg.down_factor;
      end
      prod_price = (2*DATA_W)'(price_src) * (2*DATA_W)'(factor);
      // q*Vup + (1-q)*Vdown = Vdown + q*(Vup - Vdown), exact in signed form
      diff   = $signed({1'b0, value_rd_ff}) - $signed({1'b0, vprev_ff});
      prod_q = diff * $signed({1'b0, cfg.up_prob});
   end

   always_ff @(posedge clock) begin
      if (s1_op_ff.valid && !s1_op_ff.fwd) begin
         vprev_ff <= value_rd_ff;
      end
      s2_prodp_ff <= prod_price;
      s2_qterm_ff <= prod_q[2*DATA_W-1:DATA_W];
      s2_vdown_ff <= vprev_ff;
   end

   always_comb begin
      if (|s2_prodp_ff[2*DATA_W-1:2*DATA_W-2]) begin
         price_sat = '1;
      end else begin
         price_sat = s2_prodp_ff[2*DATA_W-3:DATA_W-2];
      end
   end

   always_ff @(posedge clock) begin
      s3_price_ff  <= price_sat;
      s3_expect_ff <= s2_vdown_ff + s2_qterm_ff;
   end

   always_ff @(posedge clock) begin
      s4_holdp_ff <= (2*DATA_W)'(s3_expect_ff) * (2*DATA_W)'(cfg.discount_factor);
      s4_ex_ff    <= (strike > s3_price_ff) ? strike - s3_price_ff : '0;
      s4_price_ff <= s3_price_ff;
   end

   always_comb begin
      hold      = s4_op_ff.fwd ? '0 : s4_holdp_ff[2*DATA_W-1:DATA_W];
      value_new = (hold > s4_ex_ff) ? hold : s4_ex_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en && s4_op_ff.last) begin
         result_ff <= value_new;
      end
   end

   assign result = result_ff;

endmodule

[src/binomial_american_put_pricer.sv]
// Processes one tree node per cycle through the shared price/value memories, pausing at
// every tree level until the node pipeline has drained. One item at a time; the next
// is taken once the result sits in the output register. Reset clears control and
// restores register defaults; the row memories are not cleared.
module binomial_american_put_pricer import bapp_pkg::*; #(
   parameter int MAX_STEPS = 256
) (
   input  logic        clock,
   input  logic        reset,
   bapp_req_if.sink    req_bus,
   bapp_rsp_if.source  rsp_bus,
   bapp_csr_if.sink    csr_bus
);

   localparam int ADDR_W = $clog2(MAX_STEPS + 1);
   localparam int CMP_W  = (ADDR_W > STEPS_W) ? ADDR_W : STEPS_W;

   logic [STEPS_W-1:0] num_steps_ff;
   cfg_type            cfg_ff;

   logic [DATA_W-1:0]  spot_ff;
   logic [DATA_W-1:0]  strike_ff;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_data_ff;

   logic               seq_ready;
   logic               req_xfer;
   logic               rsp_free;
   logic               result_load;
   logic               busy;
   op_flags_type       op;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  steps;
   logic [CMP_W-1:0]   steps_ext;
   logic [CMP_W-1:0]   steps_max;
   logic [DATA_W-1:0]  result;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_steps_ff           <= NUM_STEPS_RESET;
         cfg_ff.up_factor       <= UP_FACTOR_RESET;
         cfg_ff.down_factor     <= DOWN_FACTOR_RESET;
         cfg_ff.up_prob         <= UP_PROB_RESET;
         cfg_ff.discount_factor <= DISCOUNT_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_NUM_STEPS:   num_steps_ff           <= csr_bus.data[STEPS_W-1:0];
            CSR_UP_FACTOR:   cfg_ff.up_factor       <= csr_bus.data;
            CSR_DOWN_FACTOR: cfg_ff.down_factor     <= csr_bus.data;
            CSR_UP_PROB:     cfg_ff.up_prob         <= csr_bus.data;
            CSR_DISCOUNT:    cfg_ff.discount_factor <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   // steps beyond the row depth are clamped
   assign steps_ext = CMP_W'(num_steps_ff);
   assign steps_max = CMP_W'(MAX_STEPS);
   assign steps     = ADDR_W'((steps_ext > steps_max) ? steps_max : steps_ext);

   assign req_bus.ready = seq_ready;
   assign req_xfer      = req_bus.valid && seq_ready;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         spot_ff   <= req_bus.spot_price;
         strike_ff <= req_bus.strike_price;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.put_value = rsp_data_ff;

   bapp_seq #(
      .MAX_STEPS (MAX_STEPS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_xfer),
      .steps       (steps),
      .busy        (busy),
      .rsp_free    (rsp_free),
      .ready       (seq_ready),
      .op          (op),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr),
      .result_load (result_load)
   );

   bapp_dp #(
      .MAX_STEPS (MAX_STEPS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .op      (op),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .spot    (spot_ff),
      .strike  (strike_ff),
      .cfg     (cfg_ff),
      .busy    (busy),
      .result  (result)
   );

endmodule

[sim/binomial_american_put_pricer_test.sv]
module binomial_american_put_pricer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bapp_pkg::*;

   localparam int MAX_STEPS       = 256;
   localparam int RANDOM_QUOTES   = 84;
   localparam int HOLD_OFF_CYCLES = 800;
   localparam int QUIET_LIMIT     = 250_000;
   localparam int DRAIN_CYCLES    = 32;
   localparam int PLAN_LEN        = 39;

   // unmapped register slots, writes there must be dropped
   localparam logic [IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam bit ROW_QUOTE = 1'b0;
   localparam bit ROW_WRITE = 1'b1;
   localparam bit PREDICT   = 1'b0;
   localparam bit KNOWN     = 1'b1;

   typedef struct {
      bit                kind;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] a;      // spot, or register data
      logic [DATA_W-1:0] b;      // strike
      bit                known;
      logic [DATA_W-1:0] put;
   } plan_row_type;

   logic clock;
   logic reset;

   bapp_req_if req_bus ();
   bapp_rsp_if rsp_bus ();
   bapp_csr_if csr_bus ();

   binomial_american_put_pricer #(
      .MAX_STEPS(MAX_STEPS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic [STEPS_W-1:0] tree_steps;
   cfg_type            tree_cfg;
   logic [DATA_W-1:0]  put_due_q [$];
   int                 mismatches;
   int                 hold_off_asked;
   int                 hold_off_done;
   int                 sender_odds;
   int                 sink_odds;
   plan_row_type       plan [0:PLAN_LEN-1];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // price times a Q2.30 factor, truncated, held at all ones on overflow
   function automatic logic [DATA_W-1:0] move_price(logic [DATA_W-1:0] price,
                                                    logic [DATA_W-1:0] factor);
      logic [63:0] prod;
      prod = ({32'd0, price} * {32'd0, factor}) >> 30;
      return (prod[63:32] != 32'd0) ? '1 : prod[31:0];
   endfunction

   function automatic logic [DATA_W-1:0] intrinsic(logic [DATA_W-1:0] strike,
                                                   logic [DATA_W-1:0] price);
      return (strike > price) ? strike - price : '0;
   endfunction

   function automatic logic [DATA_W-1:0] american_put(logic [DATA_W-1:0] spot,
                                                      logic [DATA_W-1:0] strike);
      logic [DATA_W-1:0] px  [0:MAX_STEPS];
      logic [DATA_W-1:0] opt [0:MAX_STEPS];
      logic [63:0]       w_up;
      logic [63:0]       w_dn;
      logic [63:0]       mean;
      logic [63:0]       disc;
      logic [DATA_W-1:0] price;
      logic [DATA_W-1:0] early;
      int                n;
      n = (tree_steps > MAX_STEPS) ? MAX_STEPS : int'(tree_steps);
      w_up = {32'd0, tree_cfg.up_prob};
      w_dn = 64'h1_0000_0000 - w_up;
      px[0] = spot;
      for (int i = 1; i <= n; i++) begin
         for (int j = i; j >= 1; j--)
            px[j] = move_price(px[j-1], tree_cfg.up_factor);
         px[0] = move_price(px[0], tree_cfg.down_factor);
      end
      for (int j = 0; j <= n; j++)
         opt[j] = intrinsic(strike, px[j]);
      for (int i = n; i >= 1; i--) begin
         for (int j = 0; j < i; j++) begin
            price = move_price(px[j+1], tree_cfg.down_factor);
            mean  = (w_up * opt[j+1] + w_dn * opt[j]) >> 32;
            disc  = mean * {32'd0, tree_cfg.discount_factor};
            early = intrinsic(strike, price);
            px[j]  = price;
            opt[j] = (disc[63:32] > early) ? disc[63:32] : early;
         end
      end
      return opt[0];
   endfunction

   // leaves valid high after the transfer; the caller lowers it
   task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_NUM_STEPS:   tree_steps = data[STEPS_W-1:0];
         CSR_UP_FACTOR:   tree_cfg.up_factor = data;
         CSR_DOWN_FACTOR: tree_cfg.down_factor = data;
         CSR_UP_PROB:     tree_cfg.up_prob = data;
         CSR_DISCOUNT:    tree_cfg.discount_factor = data;
         default: ;
      endcase
   endtask

   task automatic send_quote(logic [DATA_W-1:0] spot, logic [DATA_W-1:0] strike,
                             bit known, logic [DATA_W-1:0] put);
      req_bus.valid        <= 1'b1;
      req_bus.spot_price   <= spot;
      req_bus.strike_price <= strike;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      put_due_q.push_back(known ? put : american_put(spot, strike));
   endtask

   task automatic pause_sender();
      if (sender_odds != 0 && $urandom_range(0, 15) < sender_odds) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // a transfer always leaves something due, so valid is low whenever this returns
   task automatic wait_drained();
      if (put_due_q.size() != 0) begin
         req_bus.valid <= 1'b0;
         while (put_due_q.size() != 0) @(posedge clock);
      end
   endtask

   initial begin : rsp_sink
      int burst;
      burst = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_done != hold_off_asked) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
            hold_off_done++;
         end else if (burst > 0) begin
            rsp_bus.ready <= 1'b0;
            burst--;
         end else if (sink_odds != 0 && $urandom_range(0, 15) < sink_odds) begin
            rsp_bus.ready <= 1'b0;
            burst = $urandom_range(1, 16) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : put_check
      logic [DATA_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (put_due_q.size() == 0) begin
            $display("%0t: unexpected put_value transfer, expected none, got %h",
                     $time, rsp_bus.put_value);
            mismatches++;
         end else begin
            want = put_due_q.pop_front();
            if (rsp_bus.put_value !== want) begin
               $display("%0t: put_value mismatch, expected %h, got %h",
                        $time, want, rsp_bus.put_value);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("binomial_american_put_pricer_test failed");
      $finish;
   end

   initial begin : stimulus
      int                 random_sent;
      int                 phase;
      int                 batch;
      int                 roll;
      bit                 big_done;
      logic [STEPS_W-1:0] steps;
      logic [DATA_W-1:0]  up;
      logic [DATA_W-1:0]  dn;
      logic [DATA_W-1:0]  pu;
      logic [DATA_W-1:0]  disc;
      logic [DATA_W-1:0]  spot;
      logic [DATA_W-1:0]  strike;
      logic [63:0]        ratio;

      mismatches     = 0;
      hold_off_asked = 0;
      hold_off_done  = 0;
      sender_odds    = 0;
      sink_odds      = 0;
      random_sent    = 0;
      big_done       = 1'b0;
      tree_steps     = NUM_STEPS_RESET;
      tree_cfg       = '{UP_FACTOR_RESET, DOWN_FACTOR_RESET, UP_PROB_RESET, DISCOUNT_RESET};

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.spot_price   <= '0;
      req_bus.strike_price <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= CSR_NUM_STEPS;
      csr_bus.data         <= '0;

      // at reset factors the tree is flat and holding loses a little to the
      // discount, so the put is worth its intrinsic value
      plan = '{
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0000_0000, 32'hFFFF_FFFF, KNOWN, 32'hFFFF_FFFF},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'hFFFF_FFFF, 32'h0000_0000, KNOWN, 32'h0000_0000},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0064_0000, 32'h0064_0000, KNOWN, 32'h0000_0000},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0050_0000, 32'h0064_0000, KNOWN, 32'h0014_0000},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0000_0000, 32'h0000_0000, KNOWN, 32'h0000_0000},
         // zero steps: immediate payoff
         '{ROW_WRITE, CSR_NUM_STEPS, 32'h0000_0000, 32'h0, PREDICT, 32'h0},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0010_0000, 32'h0020_8000, KNOWN, 32'h0010_8000},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0000_0001, 32'hFFFF_FFFF, KNOWN, 32'hFFFF_FFFE},
         // upper data bits dropped: three steps
         '{ROW_WRITE, CSR_NUM_STEPS,   32'hFFFF_FE03, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_SPARE_LO,    32'h0000_0000, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_UP_FACTOR,   32'h4666_6666, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_DOWN_FACTOR, 32'h3A2E_8BA2, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_UP_PROB,     32'h7333_3333, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_DISCOUNT,    32'hFFEF_0000, 32'h0, PREDICT, 32'h0},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0064_0000, 32'h0064_0000, PREDICT, 32'h0},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0050_0000, 32'h0078_0000, PREDICT, 32'h0},
         // saturating node prices
         '{ROW_WRITE, CSR_UP_FACTOR,   32'hFFFF_FFFF, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_DOWN_FACTOR, 32'hFFFF_FFFF, 32'h0, PREDICT, 32'h0},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'hF000_0000, 32'hFFFF_FFFF, PREDICT, 32'h0},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0001_0000, 32'hFFFF_FFFF, PREDICT, 32'h0},
         // zero factors, all weight down, no discount value
         '{ROW_WRITE, CSR_UP_FACTOR,   32'h0000_0000, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_UP_PROB,     32'h0000_0000, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_DISCOUNT,    32'h0000_0000, 32'h0, PREDICT, 32'h0},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h1234_5678, 32'h8000_0000, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_DOWN_FACTOR, 32'h0000_0000, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_UP_PROB,     32'hFFFF_FFFF, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_DISCOUNT,    32'hFFFF_FFFF, 32'h0, PREDICT, 32'h0},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h8000_0000, 32'h1234_5678, PREDICT, 32'h0},
         // step count above the tree size is clamped
         '{ROW_WRITE, CSR_SPARE_HI,    32'hFFFF_FFFF, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_NUM_STEPS,   32'h0000_01FF, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_UP_FACTOR,   32'h4010_0000, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_DOWN_FACTOR, 32'h3FF0_03FF, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_UP_PROB,     32'h8000_0000, 32'h0, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_DISCOUNT,    32'hFFFF_0000, 32'h0, PREDICT, 32'h0},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0064_0000, 32'h0064_0000, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_NUM_STEPS,   32'h0000_0100, 32'h0, PREDICT, 32'h0},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0032_0000, 32'h0064_0000, PREDICT, 32'h0},
         '{ROW_WRITE, CSR_NUM_STEPS,   32'h0000_0001, 32'h0, PREDICT, 32'h0},
         '{ROW_QUOTE, CSR_NUM_STEPS, 32'h0064_0000, 32'h0070_0000, PREDICT, 32'h0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      sender_odds = 3;
      sink_odds   = 3;
      foreach (plan[r]) begin
         if (plan[r].kind == ROW_WRITE) begin
            wait_drained();
            write_reg(plan[r].idx, plan[r].a);
         end else begin
            csr_bus.valid <= 1'b0;
            pause_sender();
            send_quote(plan[r].a, plan[r].b, plan[r].known, plan[r].put);
         end
      end

      phase = 0;
      while (random_sent < RANDOM_QUOTES) begin
         wait_drained();
         if (random_sent >= RANDOM_QUOTES - 20) begin
            sender_odds = 0;
            sink_odds   = 0;
         end else begin
            sender_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            sink_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end

         roll  = $urandom_range(0, 15);
         batch = $urandom_range(3, 12);
         if (phase == 0) begin
            steps = STEPS_W'(4);
            batch = 6;
            sender_odds = 0;
         end else if (!big_done && roll == 0) begin
            steps    = STEPS_W'($urandom_range(200, 511));
            batch    = 1;
            big_done = 1'b1;
         end else if (roll == 1) begin
            steps = '0;
         end else begin
            steps = STEPS_W'($urandom_range(1, 12));
         end

         if ($urandom_range(0, 3) != 0) begin
            up    = 32'h4000_0000 + $urandom_range(0, 32'h0400_0000);
            ratio = 64'h1000_0000_0000_0000 / {32'd0, up};
            dn    = ratio[31:0];
            pu    = $urandom_range(32'h4000_0000, 32'hC000_0000);
            disc  = 32'hFFFF_FFFF - $urandom_range(0, 32'h0010_0000);
         end else begin
            up   = $urandom;
            dn   = $urandom;
            pu   = $urandom;
            disc = $urandom;
         end

         write_reg(CSR_NUM_STEPS, {{(DATA_W-STEPS_W){1'b0}}, steps});
         if ($urandom_range(0, 4) != 0) write_reg(CSR_UP_FACTOR, up);
         if ($urandom_range(0, 4) != 0) write_reg(CSR_DOWN_FACTOR, dn);
         if ($urandom_range(0, 4) != 0) write_reg(CSR_UP_PROB, pu);
         if ($urandom_range(0, 4) != 0) write_reg(CSR_DISCOUNT, disc);
         csr_bus.valid <= 1'b0;

         // receiver goes deaf while quotes keep coming, so the pricer backs up
         if (phase == 0)
            hold_off_asked++;

         for (int k = 0; k < batch; k++) begin
            roll = $urandom_range(0, 15);
            if (roll < 11) begin
               spot   = $urandom_range(32'h0000_4000, 32'h0200_0000);
               strike = spot - (spot >> 2) + $urandom_range(0, spot >> 1);
            end else if (roll < 13) begin
               spot   = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
               strike = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            end else begin
               spot   = $urandom;
               strike = $urandom;
            end
            if (sender_odds != 0 && $urandom_range(0, 31) == 0)
               wait_drained();
            pause_sender();
            send_quote(spot, strike, PREDICT, '0);
            random_sent++;
         end
         phase++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("binomial_american_put_pricer_test passed");
      else
         $display("binomial_american_put_pricer_test failed");
      $finish;
   end

endmodule
